// ===== rtl/assert_macros.svh =====
// Assertion macros of the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied
`define DEQU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied
`define DEQU_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dequ_pkg.sv =====
// Shared constants, types and codes of the double-ended queue
package dequ_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int SUM_W       = CNT_W + 1;

    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [2:0]                    kind_t;
    typedef logic [1:0]                    status_t;

    localparam kind_t KIND_PUSH_FRONT = 3'd0;
    localparam kind_t KIND_PUSH_BACK  = 3'd1;
    localparam kind_t KIND_POP_FRONT  = 3'd2;
    localparam kind_t KIND_POP_BACK   = 3'd3;
    localparam kind_t KIND_CLEAR      = 3'd4;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_UNDERFLOW = 2'd1;
    localparam status_t STATUS_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic    wr_en;
        idx_t    wr_addr;
        value_t  wr_data;
        idx_t    rd_front_addr;
        idx_t    rd_back_addr;
        status_t status;
        cnt_t    count;
        logic    fwd_front;
        logic    fwd_back;
    } ctrl_t;

endpackage

// ===== rtl/dequ_if.sv =====
// Request and response channel interfaces of the double-ended queue
interface dequ_req_if import dequ_pkg::*;;
    logic   valid;
    logic   ready;
    kind_t  kind;
    value_t push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink (input valid, input kind, input push_value, output ready);
endinterface

interface dequ_rsp_if import dequ_pkg::*;;
    logic    valid;
    logic    ready;
    status_t status;
    value_t  front_value;
    value_t  back_value;
    cnt_t    entry_count;
    logic    is_empty;

    modport source (output valid, output status, output front_value, output back_value,
                    output entry_count, output is_empty, input ready);
    modport sink (input valid, input status, input front_value, input back_value,
                  input entry_count, input is_empty, output ready);
endinterface

// ===== rtl/dequ_ram.sv =====
// Slot memory: one write port, two registered read ports
module dequ_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/dequ_ctrl.sv =====
// Head and occupancy tracking, slot addressing and status of each operation
module dequ_ctrl import dequ_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   step,
    input  kind_t  kind,
    input  value_t push_value,
    output ctrl_t  ctl
);

    idx_t head_reg;
    idx_t head_next;
    cnt_t count_reg;
    cnt_t count_next;
    logic full;
    logic empty;

    function automatic idx_t wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        begin
            r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
            return r[IDX_W-1:0];
        end
    endfunction

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        ctl.wr_en   = 1'b0;
        ctl.wr_addr = head_reg;
        ctl.wr_data = push_value;
        ctl.status  = STATUS_OK;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    ctl.status = STATUS_OVERFLOW;
                end
                else
                begin
                    head_next   = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;
                    count_next  = count_reg + 1'b1;
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = head_next;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    ctl.status = STATUS_OVERFLOW;
                end
                else
                begin
                    count_next  = count_reg + 1'b1;
                    ctl.wr_en   = 1'b1;
                    ctl.wr_addr = wrap_idx(SUM_W'(head_reg) + SUM_W'(count_reg));
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                begin
                    ctl.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    head_next  = wrap_idx(SUM_W'(head_reg) + SUM_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_POP_BACK:
            begin
                if (empty)
                begin
                    ctl.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        ctl.count         = count_next;
        ctl.rd_front_addr = head_next;
        ctl.rd_back_addr  = wrap_idx(SUM_W'(head_next) + SUM_W'(count_next) - SUM_W'(1));
        ctl.fwd_front     = ctl.wr_en && (ctl.wr_addr == ctl.rd_front_addr);
        ctl.fwd_back      = ctl.wr_en && (ctl.wr_addr == ctl.rd_back_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Top level of the bounded double-ended queue of signed values
// A transaction on req performs one operation (push front, push back, pop front, pop back or
// clear) and yields exactly one transaction on rsp carrying the status, the front and back
// values after the operation (0 when empty), the entry count and an empty flag. Entries sit
// in a 256-slot memory with one write port and two registered read ports; the memory
// read and the pending stage load at the edge that accepts the request, and the output
// register loads from them once it is empty or being drained, and then drives rsp.
// A new request is taken every cycle while responses are drained, so the sustained rate is
// one operation per cycle; a stalled rsp holds one finished response and one in flight.
// No clearing pass is needed after reset: only values from slots that hold live entries are ever used.
module double_ended_queue_unit import dequ_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    dequ_req_if.sink   req,
    dequ_rsp_if.source rsp
);

    ctrl_t   ctl;
    logic    accept;
    logic    pend_done;
    logic    pend_reg;
    logic    pend_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t status_p_reg;
    cnt_t    count_p_reg;
    logic    fwd_front_reg;
    logic    fwd_back_reg;
    value_t  fwd_data_reg;
    logic [VALUE_WIDTH-1:0] rd_front;
    logic [VALUE_WIDTH-1:0] rd_back;
    status_t status_reg;
    value_t  front_reg;
    value_t  back_reg;
    cnt_t    count_reg;
    logic    empty_reg;

    assign accept    = req.valid && req.ready;
    assign pend_done = pend_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_reg || pend_done;

    dequ_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .kind       (req.kind),
        .push_value (req.push_value),
        .ctl        (ctl)
    );

    dequ_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (accept && ctl.wr_en),
        .wr_addr   (ctl.wr_addr),
        .wr_data   (ctl.wr_data),
        .rd_en     (accept),
        .rd_addr_a (ctl.rd_front_addr),
        .rd_addr_b (ctl.rd_back_addr),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (pend_done)
        begin
            pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pend_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_p_reg  <= ctl.status;
            count_p_reg   <= ctl.count;
            fwd_front_reg <= ctl.fwd_front;
            fwd_back_reg  <= ctl.fwd_back;
            fwd_data_reg  <= ctl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_done)
        begin
            status_reg <= status_p_reg;
            count_reg  <= count_p_reg;
            empty_reg  <= (count_p_reg == '0);
            if (count_p_reg == '0)
            begin
                front_reg <= '0;
                back_reg  <= '0;
            end
            else
            begin
                front_reg <= fwd_front_reg ? fwd_data_reg : value_t'(rd_front);
                back_reg  <= fwd_back_reg ? fwd_data_reg : value_t'(rd_back);
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.front_value = front_reg;
    assign rsp.back_value  = back_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.is_empty    = empty_reg;

endmodule

// ===== rtl/dequ_chk.sv =====
// Port-level checker of the double-ended queue and its bind to the top level
`include "assert_macros.svh"

module dequ_chk import dequ_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input status_t status,
    input value_t  front_value,
    input value_t  back_value,
    input cnt_t    entry_count,
    input logic    is_empty
);

    `DEQU_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(front_value) && $stable(back_value) && $stable(entry_count) && $stable(is_empty), "stalled response changed")
    `DEQU_ASSERT_IMP(a_empty_flag, clk, rst_n, rsp_valid, is_empty == (entry_count == '0), "empty flag disagrees with count")
    `DEQU_ASSERT_IMP(a_empty_zero, clk, rst_n, rsp_valid && is_empty, front_value == '0 && back_value == '0, "empty queue shows nonzero values")
    `DEQU_ASSERT_IMP(a_count_cap, clk, rst_n, rsp_valid, entry_count <= CNT_W'(CAPACITY), "entry count above capacity")

endmodule

bind double_ended_queue_unit dequ_chk u_dequ_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty)
);
